// File: hdl/hrbd_pkg.sv
// ----------------------------------------------------------------------------
// hrbd_pkg
// Shared types and constants for the heart rate beat detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbd_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int COUNT_W   = 13;
    localparam int RATE_W    = 16;

    // Serial divider: dividend/quotient wide enough for the largest ring sum
    localparam int DIV_W     = 20;
    localparam int DVS_W     = 13;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Beats per minute from a tick count in milliseconds
    localparam logic [DIV_W-1:0]    BPM_NUMERATOR = DIV_W'(60000);
    localparam logic [SAMPLE_W-1:0] THRESH_RESET  = SAMPLE_W'(132);
    localparam logic [RATE_W-1:0]   TIMEOUT_RATE  = RATE_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_MSTART,
        S_MEAN,
        S_WB
    } state_t;

    // Divider request and status
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    // Ring push request
    typedef struct packed {
        logic              push;
        logic [RATE_W-1:0] data;
    } ring_req_t;

endpackage

`default_nettype wire

// File: hdl/hrbd_in_if.sv
// ----------------------------------------------------------------------------
// hrbd_in_if
// Sample channel: one ADC sample and enable bit per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrbd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          enable;
    logic [hrbd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output enable, output sample, input ready);
    modport sink   (input valid, input enable, input sample, output ready);
endinterface

`default_nettype wire

// File: hdl/hrbd_out_if.sv
// ----------------------------------------------------------------------------
// hrbd_out_if
// Result channel: beat rate, mean rate and indicator per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [hrbd_pkg::RATE_W-1:0] beat_rate;
    logic [hrbd_pkg::RATE_W-1:0] mean_rate;
    logic                        beat_indicator;

    modport source (output valid, output beat_rate, output mean_rate,
                    output beat_indicator, input ready);
    modport sink   (input valid, input beat_rate, input mean_rate,
                    input beat_indicator, output ready);
endinterface

`default_nettype wire

// File: hdl/hrbd_divider.sv
// ----------------------------------------------------------------------------
// hrbd_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbd_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hrbd_pkg::div_req_t           req,
    output hrbd_pkg::div_rsp_t                rsp,
    output logic [hrbd_pkg::DIV_W-1:0]        quotient
);

    logic [hrbd_pkg::DIV_W-1:0]     quo_reg,  quo_next;
    logic [hrbd_pkg::DVS_W-1:0]     rem_reg,  rem_next;
    logic [hrbd_pkg::DVS_W-1:0]     dvs_reg,  dvs_next;
    logic [hrbd_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [hrbd_pkg::DVS_W:0]       rem_sh;
    logic [hrbd_pkg::DVS_W:0]       rem_sub;
    logic                           fits;

    // One restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[hrbd_pkg::DIV_W-1]};
        fits    = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[hrbd_pkg::DIV_W-2:0], fits};
            rem_next = fits ? rem_sub[hrbd_pkg::DVS_W-1:0] : rem_sh[hrbd_pkg::DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == hrbd_pkg::DIV_CNT_W'(hrbd_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/hrbd_ring.sv
// ----------------------------------------------------------------------------
// hrbd_ring
// Ring of the last AVG_DEPTH beat rates with a running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbd_ring #(
    parameter int AVG_DEPTH = 5
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hrbd_pkg::ring_req_t        req,
    output logic [hrbd_pkg::DIV_W-1:0]      sum
);

    localparam int SUM_W = $clog2(AVG_DEPTH * 60000 + 1);
    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    logic [hrbd_pkg::RATE_W-1:0] ring_reg [AVG_DEPTH];
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;

    // Replace the oldest entry and adjust the sum
    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (req.push)
        begin
            sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(req.data);
            if (idx_reg == IDX_W'(AVG_DEPTH - 1))
                idx_next = '0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            for (int k = 0; k < AVG_DEPTH; k++)
                ring_reg[k] <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            if (req.push)
                ring_reg[idx_reg] <= req.data;
        end
    end

    assign sum = hrbd_pkg::DIV_W'(sum_reg);

endmodule

`default_nettype wire

// File: hdl/heart_rate_beat_detector.sv
// ----------------------------------------------------------------------------
// heart_rate_beat_detector
// Threshold beat detector with bpm rate and moving average of the last beats.
// Sequence: a tick without a beat goes straight to S_WB; a beat runs S_RATE
//   (rate division), S_MSTART and S_MEAN (mean division through the shared
//   serial divider), then S_WB, which loads the output register once free.
// Throughput: the next sample is taken only back in S_IDLE, after S_WB has
//   loaded the result; that result may still wait at the output.
// Reset: asynchronous; control state, ring and sum clear, threshold returns to 132.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_beat_detector #(
    parameter int AVG_DEPTH     = 5,
    parameter int TIMEOUT_TICKS = 5000
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [hrbd_pkg::SAMPLE_W-1:0]     cfg_wr_data,
    hrbd_in_if.sink                                in_ch,
    hrbd_out_if.source                             out_ch
);

    hrbd_pkg::state_t               state_reg, state_next;
    logic [hrbd_pkg::SAMPLE_W-1:0]  thresh_reg;
    logic                           level_reg, level_next;
    logic [hrbd_pkg::COUNT_W-1:0]   tc_reg, tc_next;
    logic [hrbd_pkg::RATE_W-1:0]    rate_reg, rate_next;
    logic [hrbd_pkg::RATE_W-1:0]    mean_reg, mean_next;
    logic                           ind_reg, ind_next;

    logic                           out_valid_reg, out_valid_next;
    logic [hrbd_pkg::RATE_W-1:0]    out_rate_reg, out_rate_next;
    logic [hrbd_pkg::RATE_W-1:0]    out_mean_reg, out_mean_next;
    logic                           out_ind_reg, out_ind_next;

    logic [hrbd_pkg::COUNT_W-1:0]   tc_inc;
    logic                           in_xfer;
    logic                           out_free;
    logic                           is_high;

    hrbd_pkg::div_req_t             div_req;
    hrbd_pkg::div_rsp_t             div_rsp;
    logic [hrbd_pkg::DIV_W-1:0]     div_quo;
    hrbd_pkg::ring_req_t            ring_req;
    logic [hrbd_pkg::DIV_W-1:0]     ring_sum;

    hrbd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rsp      (div_rsp),
        .quotient (div_quo)
    );

    hrbd_ring #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .sum   (ring_sum)
    );

    assign in_ch.ready = (state_reg == hrbd_pkg::S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign tc_inc      = tc_reg + 1'b1;
    assign is_high     = (in_ch.sample > thresh_reg);

    // Sequencer: next state, detector state and divider/ring control
    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        tc_next        = tc_reg;
        rate_next      = rate_reg;
        mean_next      = mean_reg;
        ind_next       = ind_reg;
        out_valid_next = out_valid_reg;
        out_rate_next  = out_rate_reg;
        out_mean_next  = out_mean_reg;
        out_ind_next   = out_ind_reg;

        div_req.start    = 1'b0;
        div_req.dividend = hrbd_pkg::BPM_NUMERATOR;
        div_req.divisor  = tc_inc;
        ring_req.push    = 1'b0;
        ring_req.data    = div_quo[hrbd_pkg::RATE_W-1:0];

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            hrbd_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = hrbd_pkg::S_WB;
                    if (in_ch.enable)
                    begin
                        if (is_high && !level_reg)
                        begin
                            // Rising crossing: rate = 60000 / ticks
                            level_next    = 1'b1;
                            ind_next      = 1'b1;
                            tc_next       = '0;
                            div_req.start = 1'b1;
                            state_next    = hrbd_pkg::S_RATE;
                        end
                        else
                        begin
                            tc_next = tc_inc;
                            if (!is_high && level_reg)
                            begin
                                level_next = 1'b0;
                                ind_next   = 1'b0;
                            end
                            // Timeout: no beat for too long
                            if (tc_inc > hrbd_pkg::COUNT_W'(TIMEOUT_TICKS))
                            begin
                                rate_next = hrbd_pkg::TIMEOUT_RATE;
                                mean_next = '0;
                                tc_next   = '0;
                                ind_next  = 1'b0;
                            end
                        end
                    end
                end
            end

            hrbd_pkg::S_RATE:
            begin
                if (div_rsp.done)
                begin
                    rate_next     = div_quo[hrbd_pkg::RATE_W-1:0];
                    ring_req.push = 1'b1;
                    state_next    = hrbd_pkg::S_MSTART;
                end
            end

            hrbd_pkg::S_MSTART:
            begin
                // Ring sum is updated; divide it by the depth
                div_req.start    = 1'b1;
                div_req.dividend = ring_sum;
                div_req.divisor  = hrbd_pkg::DVS_W'(AVG_DEPTH);
                state_next       = hrbd_pkg::S_MEAN;
            end

            hrbd_pkg::S_MEAN:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = div_quo[hrbd_pkg::RATE_W-1:0];
                    state_next = hrbd_pkg::S_WB;
                end
            end

            hrbd_pkg::S_WB:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = rate_reg;
                    out_mean_next  = mean_reg;
                    out_ind_next   = ind_reg;
                    state_next     = hrbd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hrbd_pkg::S_IDLE;
            end
        endcase
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrbd_pkg::S_IDLE;
            thresh_reg    <= hrbd_pkg::THRESH_RESET;
            level_reg     <= 1'b0;
            tc_reg        <= '0;
            rate_reg      <= '0;
            mean_reg      <= '0;
            ind_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            tc_reg        <= tc_next;
            rate_reg      <= rate_next;
            mean_reg      <= mean_next;
            ind_reg       <= ind_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                thresh_reg <= cfg_wr_data;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_rate_reg <= out_rate_next;
        out_mean_reg <= out_mean_next;
        out_ind_reg  <= out_ind_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.beat_rate      = out_rate_reg;
    assign out_ch.mean_rate      = out_mean_reg;
    assign out_ch.beat_indicator = out_ind_reg;

    // Indicator is only ever high while the level flag is high
    a_ind_level: assert property (@(posedge clk) disable iff (!rst_n)
        ind_reg |-> level_reg)
        else $error("indicator high with level flag low");

    // Tick count never passes the timeout limit
    a_tc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        tc_reg <= hrbd_pkg::COUNT_W'(TIMEOUT_TICKS))
        else $error("tick count above timeout");

    // Divider is never restarted while busy
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Ring push only with a fresh rate quotient
    a_ring_push: assert property (@(posedge clk) disable iff (!rst_n)
        ring_req.push |-> div_rsp.done && (state_reg == hrbd_pkg::S_RATE))
        else $error("ring push without rate result");

endmodule

`default_nettype wire

// File: tb/tb_heart_rate_beat_detector.sv
// ----------------------------------------------------------------------------
// tb_heart_rate_beat_detector
// Self-checking bench for the threshold beat detector. Samples go in through
// the sample channel; a local copy of the detector state predicts the rate,
// mean and indicator for every transfer, and each result transfer is checked
// against the oldest prediction. Directed tests cover the first beat, ring
// fill and wrap, threshold extremes and long runs with the flag low and held
// high; random pulse trains then run under several thresholds with idle and
// stall gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_heart_rate_beat_detector;

    localparam int AVG_DEPTH      = 5;
    localparam int TIMEOUT_TICKS  = 5000;
    localparam int BPM_TICKS      = 60000;
    localparam int GAP_PCT        = 14;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 60;
    localparam int LONG_RUN       = 100;

    typedef struct packed {
        logic [hrbd_pkg::RATE_W-1:0] beat_rate;
        logic [hrbd_pkg::RATE_W-1:0] mean_rate;
        logic                        beat_indicator;
    } beat_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [hrbd_pkg::SAMPLE_W-1:0] cfg_wr_data;

    hrbd_in_if  in_ch ();
    hrbd_out_if out_ch ();

    heart_rate_beat_detector #(
        .AVG_DEPTH     (AVG_DEPTH),
        .TIMEOUT_TICKS (TIMEOUT_TICKS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Detector state as predicted
    logic [hrbd_pkg::SAMPLE_W-1:0] thresh_q;
    logic                          level_q;
    logic [hrbd_pkg::COUNT_W-1:0]  ticks_q;
    logic [hrbd_pkg::RATE_W-1:0]   rate_ring_q [AVG_DEPTH];
    int                            ring_pos_q;
    logic [hrbd_pkg::RATE_W-1:0]   rate_q;
    logic [hrbd_pkg::RATE_W-1:0]   mean_q;
    logic                          indicator_q;

    beat_result_t expected_results[$];
    bit           gaps_on;
    int           error_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicted detector step for one sample transfer
    function automatic beat_result_t detect_tick(input logic en,
                                                 input logic [hrbd_pkg::SAMPLE_W-1:0] smp);
        beat_result_t res;
        int           ring_sum;
        if (en)
        begin
            ticks_q = ticks_q + 1'b1;
            if (smp > thresh_q && !level_q)
            begin
                level_q     = 1'b1;
                indicator_q = 1'b1;
                rate_q      = hrbd_pkg::RATE_W'(BPM_TICKS / int'(ticks_q));
                ticks_q     = '0;
                rate_ring_q[ring_pos_q] = rate_q;
                ring_pos_q  = (ring_pos_q + 1) % AVG_DEPTH;
                ring_sum    = 0;
                foreach (rate_ring_q[k])
                    ring_sum += int'(rate_ring_q[k]);
                mean_q      = hrbd_pkg::RATE_W'(ring_sum / AVG_DEPTH);
            end
            if (smp <= thresh_q && level_q)
            begin
                level_q     = 1'b0;
                indicator_q = 1'b0;
            end
            // no beat for too long: rate floors, flag untouched
            if (int'(ticks_q) > TIMEOUT_TICKS)
            begin
                rate_q      = hrbd_pkg::TIMEOUT_RATE;
                ticks_q     = '0;
                indicator_q = 1'b0;
                mean_q      = '0;
            end
        end
        res.beat_rate      = rate_q;
        res.mean_rate      = mean_q;
        res.beat_indicator = indicator_q;
        return res;
    endfunction

    // One sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input logic en, input logic [hrbd_pkg::SAMPLE_W-1:0] smp);
        while (gaps_on && $urandom_range(99) < GAP_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.enable <= en;
        in_ch.sample <= smp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(detect_tick(en, smp));
    endtask

    // Threshold write once all results are back and the sequencer has drained
    task automatic set_threshold(input logic [hrbd_pkg::SAMPLE_W-1:0] level);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thresh_q     = level;
    endtask

    function automatic logic [hrbd_pkg::SAMPLE_W-1:0] low_sample();
        if ($urandom_range(99) < 10)
            return hrbd_pkg::SAMPLE_W'($urandom_range(4095));
        return hrbd_pkg::SAMPLE_W'($urandom_range(int'(thresh_q)));
    endfunction

    function automatic logic [hrbd_pkg::SAMPLE_W-1:0] high_sample();
        if ($urandom_range(99) < 10 || thresh_q == '1)
            return hrbd_pkg::SAMPLE_W'($urandom_range(4095));
        return hrbd_pkg::SAMPLE_W'($urandom_range(4095, int'(thresh_q) + 1));
    endfunction

    function automatic logic pick_enable();
        return ($urandom_range(99) >= 8);
    endfunction

    // Beat right on the first tick, disabled ticks, edges around the threshold
    task automatic test_first_beat();
        send_sample(1'b1, 12'hFFF);
        send_sample(1'b1, 12'h000);
        send_sample(1'b0, 12'hFFF);
        send_sample(1'b0, 12'h000);
        send_sample(1'b1, 12'd132);
        send_sample(1'b1, 12'd133);
        send_sample(1'b1, 12'd133);
        send_sample(1'b1, 12'd132);
    endtask

    // Beats at growing spacing fill the ring and wrap it
    task automatic test_ring_fill();
        for (int gap = 1; gap <= 7; gap++)
        begin
            repeat (gap) send_sample(1'b1, 12'd0);
            send_sample(1'b1, 12'd3000);
        end
    endtask

    // Register extremes: zero threshold and full-scale threshold
    task automatic test_threshold_extremes();
        set_threshold(12'h000);
        send_sample(1'b1, 12'd0);
        send_sample(1'b1, 12'd1);
        send_sample(1'b1, 12'd0);
        set_threshold(12'hFFF);
        send_sample(1'b1, 12'hFFF);
        send_sample(1'b1, 12'h000);
        set_threshold(hrbd_pkg::THRESH_RESET);
    endtask

    // Long run with the flag low, then a long hold with the flag high
    task automatic test_long_hold();
        repeat (LONG_RUN) send_sample(1'b1, 12'd10);
        send_sample(1'b1, 12'd2000);
        repeat (LONG_RUN) send_sample(1'b1, 12'd2000);
        send_sample(1'b1, 12'd3000);
        send_sample(1'b1, 12'd20);
        send_sample(1'b1, 12'd3000);
        send_sample(1'b1, 12'd20);
    endtask

    // Random pulse trains: low runs, high runs, some noise and disabled ticks
    task automatic run_pulse_phase(input int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 3)
                run_len = $urandom_range(200, 40);
            else
                run_len = $urandom_range(24, 1);
            repeat (run_len) send_sample(pick_enable(), low_sample());
            sent += run_len;
            run_len = $urandom_range(8, 1);
            repeat (run_len) send_sample(pick_enable(), high_sample());
            sent += run_len;
        end
    endtask

    task automatic test_random_phases();
        logic [hrbd_pkg::SAMPLE_W-1:0] levels[6];
        levels = '{hrbd_pkg::THRESH_RESET, 12'h000, 12'hFFF, 12'd2048,
                   hrbd_pkg::SAMPLE_W'($urandom_range(4095)),
                   hrbd_pkg::SAMPLE_W'($urandom_range(4095))};
        foreach (levels[p])
        begin
            set_threshold(levels[p]);
            // one phase runs with no idling on either side
            gaps_on = (p != 3);
            run_pulse_phase(PHASE_ITEMS);
        end
        gaps_on = 1'b1;
    endtask

    // Main sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_ch.valid  = 1'b0;
        in_ch.enable = 1'b0;
        in_ch.sample = '0;
        gaps_on      = 1'b1;
        error_count  = 0;
        thresh_q     = hrbd_pkg::THRESH_RESET;
        level_q      = 1'b0;
        ticks_q      = '0;
        foreach (rate_ring_q[k])
            rate_ring_q[k] = '0;
        ring_pos_q   = 0;
        rate_q       = '0;
        mean_q       = '0;
        indicator_q  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_beat();
        test_ring_fill();
        test_threshold_extremes();
        test_long_hold();
        test_random_phases();

        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result checking and random back-pressure
    initial
    begin
        beat_result_t exp_r;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer rate=%0d mean=%0d ind=%0b",
                             $time, out_ch.beat_rate, out_ch.mean_rate,
                             out_ch.beat_indicator);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.beat_rate !== exp_r.beat_rate)
                    begin
                        $display("%0t: beat_rate expected %0d actual %0d",
                                 $time, exp_r.beat_rate, out_ch.beat_rate);
                        error_count++;
                    end
                    if (out_ch.mean_rate !== exp_r.mean_rate)
                    begin
                        $display("%0t: mean_rate expected %0d actual %0d",
                                 $time, exp_r.mean_rate, out_ch.mean_rate);
                        error_count++;
                    end
                    if (out_ch.beat_indicator !== exp_r.beat_indicator)
                    begin
                        $display("%0t: beat_indicator expected %0b actual %0b",
                                 $time, exp_r.beat_indicator, out_ch.beat_indicator);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
        end
    end

    // Watchdog: too long without any transfer on either channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog timeout, %0d results outstanding",
                         $time, expected_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
